// ===== src/mtsct_pkg.sv =====
package mtsct_pkg;

   localparam int PANEL_WIDTH  = 1620;
   localparam int PANEL_HEIGHT = 2160;
   localparam int RAW_WIDTH    = 2064;
   localparam int RAW_HEIGHT   = 2832;

   // event types and codes
   localparam logic [4:0] EV_SYN = 5'd0;
   localparam logic [4:0] EV_ABS = 5'd3;

   localparam logic [9:0] CODE_REPORT = 10'h000;
   localparam logic [9:0] CODE_SLOT   = 10'h02f;
   localparam logic [9:0] CODE_POS_X  = 10'h035;
   localparam logic [9:0] CODE_POS_Y  = 10'h036;
   localparam logic [9:0] CODE_TRACK  = 10'h039;

   localparam int X_BITS     = 11;
   localparam int Y_BITS     = 12;
   localparam int PIX_BITS   = 12;
   localparam int DX_BITS    = 12;
   localparam int DY_BITS    = 13;
   localparam int DWELL_BITS = 16;

   localparam int RAW_X_BITS = $clog2(RAW_WIDTH);
   localparam int RAW_Y_BITS = $clog2(RAW_HEIGHT);
   localparam int RAW_BITS   = (RAW_X_BITS > RAW_Y_BITS) ? RAW_X_BITS : RAW_Y_BITS;

   // floor(r * panel / raw) == (r * mult) >> shift for every r below raw
   localparam int SHIFT_X = 2 * RAW_X_BITS;
   localparam int SHIFT_Y = 2 * RAW_Y_BITS;
   localparam longint unsigned MULT_X =
      ((longint'(PANEL_WIDTH) << SHIFT_X) + longint'(RAW_WIDTH) - 1) / longint'(RAW_WIDTH);
   localparam longint unsigned MULT_Y =
      ((longint'(PANEL_HEIGHT) << SHIFT_Y) + longint'(RAW_HEIGHT) - 1) / longint'(RAW_HEIGHT);
   localparam longint unsigned MULT_MAX = (MULT_X > MULT_Y) ? MULT_X : MULT_Y;
   localparam int MULT_BITS = $clog2(MULT_MAX + 1);
   localparam int PROD_BITS = RAW_BITS + MULT_BITS;

   typedef struct packed {
      logic [31:0]        time_ms;
      logic signed [31:0] event_value;
      logic [9:0]         event_code;
      logic [4:0]         event_type;
   } evt_type;

   typedef struct packed {
      logic [DWELL_BITS-1:0]    dwell_ms;
      logic [Y_BITS-1:0]        end_y;
      logic [X_BITS-1:0]        end_x;
      logic signed [DY_BITS-1:0] delta_y;
      logic signed [DX_BITS-1:0] delta_x;
   } rsp_type;

   typedef struct packed {
      logic first_slot;
      logic contact_down;
      logic pending_start;
      logic pending_end;
   } trk_status_type;

endpackage

// ===== src/mtsct_scale.sv =====
module mtsct_scale
   import mtsct_pkg::*;
(
   input  logic signed [31:0]  raw_value,
   input  logic                axis_y,
   output logic [PIX_BITS-1:0] pixel
);

   logic [RAW_BITS-1:0]  lim;
   logic [RAW_BITS-1:0]  clamped;
   logic [MULT_BITS-1:0] mult;
   logic [PROD_BITS-1:0] prod;
   logic [PROD_BITS-1:0] shifted;

   always_comb begin
      lim  = axis_y ? RAW_BITS'(RAW_HEIGHT - 1) : RAW_BITS'(RAW_WIDTH - 1);
      mult = axis_y ? MULT_BITS'(MULT_Y) : MULT_BITS'(MULT_X);
      if (raw_value[31]) begin
         clamped = '0;
      end else if (raw_value[30:0] > 31'(lim)) begin
         clamped = lim;
      end else begin
         clamped = raw_value[RAW_BITS-1:0];
      end
      prod    = PROD_BITS'(clamped) * PROD_BITS'(mult);
      shifted = axis_y ? (prod >> SHIFT_Y) : (prod >> SHIFT_X);
      pixel   = shifted[PIX_BITS-1:0];
   end

endmodule

// ===== src/mtsct_track.sv =====
module mtsct_track
   import mtsct_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  evt_type        evt,
   output logic           res_valid,
   output rsp_type        res,
   output trk_status_type status
);

   logic              first_slot_ff, first_slot_in;
   logic [X_BITS-1:0] cur_x_ff, cur_x_in, start_x_ff, start_x_in;
   logic [Y_BITS-1:0] cur_y_ff, cur_y_in, start_y_ff, start_y_in;
   logic              down_ff, down_in;
   logic              pend_start_ff, pend_start_in;
   logic              pend_end_ff, pend_end_in;
   logic [31:0]       start_time_ff, start_time_in;

   logic                is_sync, is_abs;
   logic [PIX_BITS-1:0] pixel;
   logic [X_BITS-1:0]   eff_sx;
   logic [Y_BITS-1:0]   eff_sy;
   logic [31:0]         eff_time, dwell_full;
   logic                eff_down;

   mtsct_scale u_scale (
      .raw_value (evt.event_value),
      .axis_y    (evt.event_code == CODE_POS_Y),
      .pixel     (pixel)
   );

   always_comb begin
      is_sync  = (evt.event_type == EV_SYN) && (evt.event_code == CODE_REPORT);
      is_abs   = (evt.event_type == EV_ABS);
      // a start pending in this frame resolves before the lift
      eff_down = down_ff | pend_start_ff;
      eff_sx   = pend_start_ff ? cur_x_ff : start_x_ff;
      eff_sy   = pend_start_ff ? cur_y_ff : start_y_ff;
      eff_time = pend_start_ff ? evt.time_ms : start_time_ff;

      dwell_full  = evt.time_ms - eff_time;
      res_valid   = is_sync && pend_end_ff && eff_down;
      res.delta_x = DX_BITS'({1'b0, cur_x_ff} - {1'b0, eff_sx});
      res.delta_y = DY_BITS'({1'b0, cur_y_ff} - {1'b0, eff_sy});
      res.end_x   = cur_x_ff;
      res.end_y   = cur_y_ff;
      res.dwell_ms = (|dwell_full[31:DWELL_BITS]) ? '1 : dwell_full[DWELL_BITS-1:0];
   end

   always_comb begin
      first_slot_in = first_slot_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      down_in       = down_ff;
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;
      start_time_in = start_time_ff;
      if (is_sync) begin
         if (pend_start_ff) begin
            down_in       = 1'b1;
            start_x_in    = cur_x_ff;
            start_y_in    = cur_y_ff;
            start_time_in = evt.time_ms;
            pend_start_in = 1'b0;
         end
         if (pend_end_ff) begin
            down_in     = 1'b0;
            pend_end_in = 1'b0;
         end
      end else if (is_abs) begin
         if (evt.event_code == CODE_SLOT) begin
            first_slot_in = (evt.event_value == 32'sd0);
         end else if (first_slot_ff) begin
            case (evt.event_code)
               CODE_POS_X: cur_x_in = pixel[X_BITS-1:0];
               CODE_POS_Y: cur_y_in = pixel[Y_BITS-1:0];
               CODE_TRACK: begin
                  if (evt.event_value[31]) begin
                     pend_end_in = 1'b1;
                  end else begin
                     pend_start_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_slot_ff <= 1'b1;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         down_ff       <= 1'b0;
         pend_start_ff <= 1'b0;
         pend_end_ff   <= 1'b0;
         start_time_ff <= '0;
      end else if (step_en) begin
         first_slot_ff <= first_slot_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
         start_x_ff    <= start_x_in;
         start_y_ff    <= start_y_in;
         down_ff       <= down_in;
         pend_start_ff <= pend_start_in;
         pend_end_ff   <= pend_end_in;
         start_time_ff <= start_time_in;
      end
   end

   assign status.first_slot    = first_slot_ff;
   assign status.contact_down  = down_ff;
   assign status.pending_start = pend_start_ff;
   assign status.pending_end   = pend_end_ff;

endmodule

// ===== src/multitouch_slot_contact_tracker_core.sv =====
// a result travels from the input register, through the tracker logic, into the result register
// throughput: one event per cycle; the input register stalls only when the
// event held there causes a result while the result register is still full
// reset: synchronous, clears the pipeline valids and the tracker state (slot zero selected)
module multitouch_slot_contact_tracker_core
   import mtsct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // event_value[31:0], time_ms[63:32]
   input  logic [15:0] req_tuser,   // event_type[4:0], event_code[14:5], zero[15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // delta_x, delta_y, end_x, end_y, dwell_ms
);

   logic           stage_valid_ff, stage_valid_in;
   evt_type        stage_ff, stage_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           res_valid;
   rsp_type        res;
   trk_status_type status;
   logic           out_free, advance;

   mtsct_track u_track (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .evt       (stage_ff),
      .res_valid (res_valid),
      .res       (res),
      .status    (status)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      advance    = stage_valid_ff && (!res_valid || out_free);
      req_tready = !stage_valid_ff || advance;

      stage_in.event_type  = req_tuser[4:0];
      stage_in.event_code  = req_tuser[14:5];
      stage_in.event_value = req_tdata[31:0];
      stage_in.time_ms     = req_tdata[63:32];
      stage_valid_in       = req_tready ? req_tvalid : stage_valid_ff;

      rsp_in = rsp_ff;
      if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         stage_ff <= stage_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // a result is loaded only into a free result register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |-> out_free)
      else $error("result loaded over a pending transfer");

   // stalling the input needs a held event and a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (stage_valid_ff && rsp_valid_ff && !rsp_tready && res_valid))
      else $error("input stalled without cause");

   // a held event stays put until it advances
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_ff)))
      else $error("stalled event lost or changed");

   // emitting a result ends the contact
   a_contact_ends: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid) |=> (!status.contact_down && !status.pending_end
                                  && !status.pending_start))
      else $error("contact still active after result");

endmodule
